@@ sv/apsp_pkg.sv @@
// Shared types and constants for the all-pairs shortest path next hop unit.
`default_nettype none

package apsp_pkg;

    localparam int MAX_TOKENS_DEF = 64;
    localparam int CMD_W          = 2;
    localparam int NODE_W         = 6;
    localparam int TC_W           = 7;
    localparam int OUT_DIST_W     = 7;

    typedef enum logic [1:0] {
        CMD_START   = 2'd0,
        CMD_EDGE    = 2'd1,
        CMD_CLOSURE = 2'd2,
        CMD_QUERY   = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_EDGE_FWD,
        S_EDGE_REV,
        S_QUERY_RD,
        S_IK_RD,
        S_IK_CHK,
        S_J_RD,
        S_J_WR,
        S_FINISH
    } t_state;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_QUERY,
        RD_IK,
        RD_J
    } t_rd_sel;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_FWD,
        WR_REV,
        WR_CLEAR,
        WR_RELAX
    } t_wr_sel;

    typedef struct packed {
        logic    accept;
        logic    clr_i;
        logic    inc_i;
        logic    clr_j;
        logic    inc_j;
        logic    clr_k;
        logic    inc_k;
        logic    latch_ik;
        logic    load_result;
        t_rd_sel rd_sel;
        t_wr_sel wr_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic in_bad;
        logic i_last;
        logic j_last;
        logic k_last;
        logic i_eq_k;
        logic j_eq_k;
        logic dik_unreach;
        logic relax;
        logic slot_free;
    } t_dp_stat;

endpackage

`default_nettype wire

@@ sv/all_pairs_shortest_path_next_hop_unit.sv @@
// Top level of the all-pairs shortest path next hop unit.
//
//   Channel   Direction  Handshake           Payload
//   command   in         i_valid / o_ready   i_cmd, i_node_a, i_node_b, i_token_count
//   result    out        o_valid / i_ready   o_distance, o_reachable, o_next_hop,
//                                            o_has_next, o_bad_node
//
// One item is worked on at a time; a finished result sits in the output register
// while the next item is taken. A query does one memory read, and an edge does one
// write to the memories per direction. A start clears N*N entries, one per cycle. A
// closure reads the distance memory and, where a path shortens, writes it back for
// each (k, i, j) step, and skips the j loop for a (k, i) where node i has no path to k.
// After reset, an initial state clears entry (0, 0) before the first transfer. An
// output stall holds the block in its final state until the result moves.
`default_nettype none

module all_pairs_shortest_path_next_hop_unit #(
    parameter int MAX_TOKENS = apsp_pkg::MAX_TOKENS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire logic [apsp_pkg::CMD_W-1:0]       i_cmd,
    input  wire logic [apsp_pkg::NODE_W-1:0]      i_node_a,
    input  wire logic [apsp_pkg::NODE_W-1:0]      i_node_b,
    input  wire logic [apsp_pkg::TC_W-1:0]        i_token_count,
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output logic [apsp_pkg::OUT_DIST_W-1:0]       o_distance,
    output logic                                  o_reachable,
    output logic [apsp_pkg::NODE_W-1:0]           o_next_hop,
    output logic                                  o_has_next,
    output logic                                  o_bad_node
);

    apsp_pkg::t_dp_cmd  w_dp_cmd;
    apsp_pkg::t_dp_stat w_dp_stat;

    apsp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_cmd   (i_cmd),
        .i_stat  (w_dp_stat),
        .o_cmd   (w_dp_cmd)
    );

    apsp_dpath #(
        .MAX_TOKENS (MAX_TOKENS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (i_cmd),
        .i_node_a      (i_node_a),
        .i_node_b      (i_node_b),
        .i_token_count (i_token_count),
        .i_dp_cmd      (w_dp_cmd),
        .o_stat        (w_dp_stat),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_distance    (o_distance),
        .o_reachable   (o_reachable),
        .o_next_hop    (o_next_hop),
        .o_has_next    (o_has_next),
        .o_bad_node    (o_bad_node)
    );

`ifndef SYNTH
    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dp_cmd.load_result |-> (!o_valid || i_ready))
        else $error("A result was loaded over one that was not transferred.");

    a_one_item_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("A second item was taken while the first was still in work.");

    a_valid_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(w_dp_cmd.load_result))
        else $error("A result appeared without a load from the controller.");

    a_relax_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_dp_cmd.wr_sel == apsp_pkg::WR_RELAX) |-> (w_dp_cmd.rd_sel == apsp_pkg::RD_NONE))
        else $error("A relaxation write overlapped a memory read.");
`endif

endmodule

`default_nettype wire

@@ sv/apsp_ctrl.sv @@
// Controller state machine that sequences clearing, edge loads, queries and the closure.
`default_nettype none

module apsp_ctrl (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [apsp_pkg::CMD_W-1:0] i_cmd,
    input  wire apsp_pkg::t_dp_stat         i_stat,
    output apsp_pkg::t_dp_cmd               o_cmd
);

    apsp_pkg::t_state r_state;
    apsp_pkg::t_state n_state;
    apsp_pkg::t_state w_adv_i_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= apsp_pkg::S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign w_adv_i_state = (i_stat.i_last && i_stat.k_last) ? apsp_pkg::S_FINISH
                                                             : apsp_pkg::S_IK_RD;

    always_comb begin
        n_state = r_state;
        case (r_state)
            apsp_pkg::S_INIT: begin
                n_state = apsp_pkg::S_IDLE;
            end
            apsp_pkg::S_IDLE: begin
                if (i_valid) begin
                    case (apsp_pkg::t_cmd'(i_cmd))
                        apsp_pkg::CMD_START: begin
                            n_state = apsp_pkg::S_CLEAR;
                        end
                        apsp_pkg::CMD_EDGE: begin
                            n_state = i_stat.in_bad ? apsp_pkg::S_FINISH
                                                    : apsp_pkg::S_EDGE_FWD;
                        end
                        apsp_pkg::CMD_CLOSURE: begin
                            n_state = apsp_pkg::S_IK_RD;
                        end
                        apsp_pkg::CMD_QUERY: begin
                            n_state = i_stat.in_bad ? apsp_pkg::S_FINISH
                                                    : apsp_pkg::S_QUERY_RD;
                        end
                        default: begin
                            n_state = apsp_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            apsp_pkg::S_CLEAR: begin
                if (i_stat.i_last && i_stat.j_last) begin
                    n_state = apsp_pkg::S_FINISH;
                end
            end
            apsp_pkg::S_EDGE_FWD: begin
                n_state = apsp_pkg::S_EDGE_REV;
            end
            apsp_pkg::S_EDGE_REV: begin
                n_state = apsp_pkg::S_FINISH;
            end
            apsp_pkg::S_QUERY_RD: begin
                n_state = apsp_pkg::S_FINISH;
            end
            apsp_pkg::S_IK_RD: begin
                n_state = i_stat.i_eq_k ? w_adv_i_state : apsp_pkg::S_IK_CHK;
            end
            apsp_pkg::S_IK_CHK: begin
                n_state = i_stat.dik_unreach ? w_adv_i_state : apsp_pkg::S_J_RD;
            end
            apsp_pkg::S_J_RD: begin
                if (!i_stat.j_eq_k) begin
                    n_state = apsp_pkg::S_J_WR;
                end else if (i_stat.j_last) begin
                    n_state = w_adv_i_state;
                end
            end
            apsp_pkg::S_J_WR: begin
                n_state = i_stat.j_last ? w_adv_i_state : apsp_pkg::S_J_RD;
            end
            apsp_pkg::S_FINISH: begin
                if (i_stat.slot_free) begin
                    n_state = apsp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = apsp_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            apsp_pkg::S_INIT: begin
                o_cmd.wr_sel = apsp_pkg::WR_CLEAR;
            end
            apsp_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    o_cmd.clr_i  = 1'b1;
                    o_cmd.clr_j  = 1'b1;
                    o_cmd.clr_k  = 1'b1;
                end
            end
            apsp_pkg::S_CLEAR: begin
                o_cmd.wr_sel = apsp_pkg::WR_CLEAR;
                if (i_stat.j_last) begin
                    o_cmd.clr_j = 1'b1;
                    o_cmd.inc_i = 1'b1;
                end else begin
                    o_cmd.inc_j = 1'b1;
                end
            end
            apsp_pkg::S_EDGE_FWD: begin
                o_cmd.wr_sel = apsp_pkg::WR_FWD;
            end
            apsp_pkg::S_EDGE_REV: begin
                o_cmd.wr_sel = apsp_pkg::WR_REV;
            end
            apsp_pkg::S_QUERY_RD: begin
                o_cmd.rd_sel = apsp_pkg::RD_QUERY;
            end
            apsp_pkg::S_IK_RD: begin
                if (i_stat.i_eq_k) begin
                    o_cmd.clr_i = i_stat.i_last;
                    o_cmd.inc_k = i_stat.i_last;
                    o_cmd.inc_i = !i_stat.i_last;
                end else begin
                    o_cmd.rd_sel = apsp_pkg::RD_IK;
                end
            end
            apsp_pkg::S_IK_CHK: begin
                if (i_stat.dik_unreach) begin
                    o_cmd.clr_i = i_stat.i_last;
                    o_cmd.inc_k = i_stat.i_last;
                    o_cmd.inc_i = !i_stat.i_last;
                end else begin
                    o_cmd.latch_ik = 1'b1;
                    o_cmd.clr_j    = 1'b1;
                end
            end
            apsp_pkg::S_J_RD: begin
                if (!i_stat.j_eq_k) begin
                    o_cmd.rd_sel = apsp_pkg::RD_J;
                end else if (i_stat.j_last) begin
                    o_cmd.clr_i = i_stat.i_last;
                    o_cmd.inc_k = i_stat.i_last;
                    o_cmd.inc_i = !i_stat.i_last;
                end else begin
                    o_cmd.inc_j = 1'b1;
                end
            end
            apsp_pkg::S_J_WR: begin
                if (i_stat.relax) begin
                    o_cmd.wr_sel = apsp_pkg::WR_RELAX;
                end
                if (i_stat.j_last) begin
                    o_cmd.clr_i = i_stat.i_last;
                    o_cmd.inc_k = i_stat.i_last;
                    o_cmd.inc_i = !i_stat.i_last;
                end else begin
                    o_cmd.inc_j = 1'b1;
                end
            end
            apsp_pkg::S_FINISH: begin
                o_cmd.load_result = i_stat.slot_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ sv/apsp_dpath.sv @@
// Datapath with the distance and next hop memories, loop counters and the output register.
`default_nettype none

module apsp_dpath #(
    parameter int MAX_TOKENS = apsp_pkg::MAX_TOKENS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic [apsp_pkg::CMD_W-1:0]       i_cmd,
    input  wire logic [apsp_pkg::NODE_W-1:0]      i_node_a,
    input  wire logic [apsp_pkg::NODE_W-1:0]      i_node_b,
    input  wire logic [apsp_pkg::TC_W-1:0]        i_token_count,
    input  wire apsp_pkg::t_dp_cmd                i_dp_cmd,
    output apsp_pkg::t_dp_stat                    o_stat,
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output logic [apsp_pkg::OUT_DIST_W-1:0]       o_distance,
    output logic                                  o_reachable,
    output logic [apsp_pkg::NODE_W-1:0]           o_next_hop,
    output logic                                  o_has_next,
    output logic                                  o_bad_node
);

    localparam int IDX_W   = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
    localparam int CNT_W   = $clog2(MAX_TOKENS + 1);
    localparam int DIST_W  = IDX_W + 1;
    localparam int NEXT_W  = IDX_W + 1;
    localparam int ADDR_W  = 2 * IDX_W;
    localparam int DEPTH   = 1 << ADDR_W;
    localparam int OUT_DW  = apsp_pkg::OUT_DIST_W;
    localparam int OUT_NW  = apsp_pkg::NODE_W;
    localparam logic [DIST_W-1:0] DIST_UNREACH = '1;
    localparam logic [NEXT_W-1:0] NEXT_NONE    = '1;

    logic [DIST_W-1:0] r_dist_mem [DEPTH];
    logic [NEXT_W-1:0] r_next_mem [DEPTH];
    logic [DIST_W-1:0] r_rdata_a;
    logic [DIST_W-1:0] r_rdata_b;
    logic [NEXT_W-1:0] r_rdata_n;

    logic [CNT_W-1:0]  r_node_count;
    logic [IDX_W-1:0]  r_i;
    logic [IDX_W-1:0]  r_j;
    logic [IDX_W-1:0]  r_k;
    logic [IDX_W-1:0]  r_a;
    logic [IDX_W-1:0]  r_b;
    apsp_pkg::t_cmd    r_cmd;
    logic              r_bad;
    logic [DIST_W-1:0] r_dik;
    logic [NEXT_W-1:0] r_nik;

    logic [CNT_W-1:0]  w_tc_clamped;
    logic              w_in_bad;
    logic [DIST_W:0]   w_sum;
    logic              w_rd_a_en;
    logic              w_rd_b_en;
    logic              w_rd_n_en;
    logic [ADDR_W-1:0] w_addr_a;
    logic [ADDR_W-1:0] w_addr_n;
    logic              w_wr_en;
    logic [ADDR_W-1:0] w_wr_addr;
    logic [DIST_W-1:0] w_wr_dist;
    logic [NEXT_W-1:0] w_wr_next;
    logic              w_slot_free;

    always_comb begin
        w_tc_clamped = CNT_W'(MAX_TOKENS);
        if (i_token_count == '0) begin
            w_tc_clamped = CNT_W'(1);
        end else if (32'(i_token_count) <= 32'(MAX_TOKENS)) begin
            w_tc_clamped = CNT_W'(i_token_count);
        end
    end

    assign w_in_bad = (32'(i_node_a) >= 32'(r_node_count))
                   || (32'(i_node_b) >= 32'(r_node_count));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= CNT_W'(1);
            r_i          <= '0;
            r_j          <= '0;
            r_k          <= '0;
        end else begin
            if (i_dp_cmd.accept && (apsp_pkg::t_cmd'(i_cmd) == apsp_pkg::CMD_START)) begin
                r_node_count <= w_tc_clamped;
            end
            if (i_dp_cmd.clr_i) begin
                r_i <= '0;
            end else if (i_dp_cmd.inc_i) begin
                r_i <= r_i + IDX_W'(1);
            end
            if (i_dp_cmd.clr_j) begin
                r_j <= '0;
            end else if (i_dp_cmd.inc_j) begin
                r_j <= r_j + IDX_W'(1);
            end
            if (i_dp_cmd.clr_k) begin
                r_k <= '0;
            end else if (i_dp_cmd.inc_k) begin
                r_k <= r_k + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.accept) begin
            r_cmd <= apsp_pkg::t_cmd'(i_cmd);
            r_a   <= IDX_W'(i_node_a);
            r_b   <= IDX_W'(i_node_b);
            r_bad <= w_in_bad && ((apsp_pkg::t_cmd'(i_cmd) == apsp_pkg::CMD_EDGE)
                               || (apsp_pkg::t_cmd'(i_cmd) == apsp_pkg::CMD_QUERY));
        end
        if (i_dp_cmd.latch_ik) begin
            r_dik <= r_rdata_a;
            r_nik <= r_rdata_n;
        end
    end

    always_comb begin
        w_addr_a = {r_a, r_b};
        case (i_dp_cmd.rd_sel)
            apsp_pkg::RD_IK: begin
                w_addr_a = {r_i, r_k};
            end
            apsp_pkg::RD_J: begin
                w_addr_a = {r_k, r_j};
            end
            default: begin
                w_addr_a = {r_a, r_b};
            end
        endcase
    end

    assign w_addr_n  = (i_dp_cmd.rd_sel == apsp_pkg::RD_IK) ? {r_i, r_k} : {r_a, r_b};
    assign w_rd_a_en = (i_dp_cmd.rd_sel != apsp_pkg::RD_NONE);
    assign w_rd_b_en = (i_dp_cmd.rd_sel == apsp_pkg::RD_J);
    assign w_rd_n_en = (i_dp_cmd.rd_sel == apsp_pkg::RD_QUERY)
                    || (i_dp_cmd.rd_sel == apsp_pkg::RD_IK);

    assign w_sum = {1'b0, r_dik} + {1'b0, r_rdata_a};

    always_comb begin
        w_wr_en   = 1'b1;
        w_wr_addr = {r_i, r_j};
        w_wr_dist = DIST_UNREACH;
        w_wr_next = NEXT_NONE;
        case (i_dp_cmd.wr_sel)
            apsp_pkg::WR_FWD: begin
                w_wr_addr = {r_a, r_b};
                w_wr_dist = DIST_W'(1);
                w_wr_next = {1'b0, r_b};
            end
            apsp_pkg::WR_REV: begin
                w_wr_addr = {r_b, r_a};
                w_wr_dist = DIST_W'(1);
                w_wr_next = {1'b0, r_a};
            end
            apsp_pkg::WR_CLEAR: begin
                w_wr_addr = {r_i, r_j};
            end
            apsp_pkg::WR_RELAX: begin
                w_wr_addr = {r_i, r_j};
                w_wr_dist = w_sum[DIST_W-1:0];
                w_wr_next = r_nik;
            end
            default: begin
                w_wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_dist_mem[w_wr_addr] <= w_wr_dist;
        end
        if (w_rd_a_en) begin
            r_rdata_a <= r_dist_mem[w_addr_a];
        end
        if (w_rd_b_en) begin
            r_rdata_b <= r_dist_mem[{r_i, r_j}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_next_mem[w_wr_addr] <= w_wr_next;
        end
        if (w_rd_n_en) begin
            r_rdata_n <= r_next_mem[w_addr_n];
        end
    end

    assign w_slot_free = !o_valid || i_ready;

    always_comb begin
        o_stat.in_bad      = w_in_bad;
        o_stat.i_last      = ((CNT_W'(r_i) + CNT_W'(1)) == r_node_count);
        o_stat.j_last      = ((CNT_W'(r_j) + CNT_W'(1)) == r_node_count);
        o_stat.k_last      = ((CNT_W'(r_k) + CNT_W'(1)) == r_node_count);
        o_stat.i_eq_k      = (r_i == r_k);
        o_stat.j_eq_k      = (r_j == r_k);
        o_stat.dik_unreach = (r_rdata_a == DIST_UNREACH);
        o_stat.relax       = (r_rdata_a != DIST_UNREACH) && (w_sum < {1'b0, r_rdata_b});
        o_stat.slot_free   = w_slot_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_dp_cmd.load_result) begin
            o_valid <= 1'b1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load_result) begin
            o_distance  <= '0;
            o_reachable <= 1'b0;
            o_next_hop  <= '0;
            o_has_next  <= 1'b0;
            o_bad_node  <= r_bad;
            if ((r_cmd == apsp_pkg::CMD_QUERY) && !r_bad) begin
                if (r_rdata_a != DIST_UNREACH) begin
                    o_distance  <= OUT_DW'(r_rdata_a);
                    o_reachable <= 1'b1;
                end
                if (r_rdata_n != NEXT_NONE) begin
                    o_next_hop <= OUT_NW'(r_rdata_n[IDX_W-1:0]);
                    o_has_next <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire
